FILE: src/ibt_pkg.sv
// Shared types and codes for the interval booking table.
`timescale 1ns / 1ps
`default_nettype none
package ibt_pkg;

  // Result status codes.
  localparam logic [1:0] ST_BOOKED  = 2'd0;
  localparam logic [1:0] ST_OVERLAP = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  // Width of a time value.
  localparam int TIME_W = 31;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new request and restart the scan
    logic scan;    // step through stored intervals
    logic decide;  // resolve status, store if booked, load the output register
  } ibt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // all stored intervals compared
    logic out_free;   // output register can take a result this cycle
  } ibt_sts_t;

endpackage
`default_nettype wire

FILE: src/ibt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ibt_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: src/ibt_ctrl.sv
// Controller state machine for the interval booking table.
`timescale 1ns / 1ps
`default_nettype none
module ibt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ibt_pkg::ibt_sts_t sts,
  output ibt_pkg::ibt_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  state_t state;
  state_t state_next;

  // Commands follow from the state, with load qualified by in_valid and decide by out_free.
  always_comb begin
    in_ready   = (state == S_IDLE);
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.scan   = (state == S_SCAN);
    cmd.decide = (state == S_DECIDE) && sts.out_free;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/ibt_dp.sv
// Datapath: request registers, interval store, overlap scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module ibt_dp #(
  parameter int CAPACITY = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [ibt_pkg::TIME_W-1:0]   req_start,
  input  wire logic [ibt_pkg::TIME_W-1:0]   req_end,
  input  wire ibt_pkg::ibt_cmd_t            cmd,
  output ibt_pkg::ibt_sts_t                 sts,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        status,
  output logic                              booked
);

  localparam int TW = ibt_pkg::TIME_W;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  logic [TW-1:0] req_s;
  logic [TW-1:0] req_e;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_addr;
  logic          rd_pending;
  logic          hit;
  logic          invalid;
  logic          rd_en;
  logic          store;
  logic [1:0]    status_next;
  logic [2*TW-1:0] rdata;
  logic [TW-1:0] slot_s;
  logic [TW-1:0] slot_e;

  assign invalid = (req_e <= req_s);
  assign slot_s  = rdata[2*TW-1:TW];
  assign slot_e  = rdata[TW-1:0];

  // One read is issued per cycle during the scan of a valid request while stored entries remain.
  assign rd_en = cmd.scan && !invalid && (rd_addr < count);

  assign sts.scan_done = cmd.scan && !rd_en && !rd_pending;
  assign sts.out_free  = !out_valid || out_ready;

  // Status resolution: invalid first, then overlap, then full.
  always_comb begin
    if (invalid) begin
      status_next = ibt_pkg::ST_INVALID;
    end else if (hit) begin
      status_next = ibt_pkg::ST_OVERLAP;
    end else if (count == CAP) begin
      status_next = ibt_pkg::ST_FULL;
    end else begin
      status_next = ibt_pkg::ST_BOOKED;
    end
  end

  assign store = cmd.decide && (status_next == ibt_pkg::ST_BOOKED);

  ibt_ram #(
    .WIDTH(2 * TW),
    .DEPTH(CAPACITY)
  ) u_slots (
    .clk  (clk),
    .we   (store),
    .waddr(count[AW-1:0]),
    .wdata({req_s, req_e}),
    .re   (rd_en),
    .raddr(rd_addr[AW-1:0]),
    .rdata(rdata)
  );

  // Request capture, scan pointer and overlap flag.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_s <= req_start;
      req_e <= req_end;
    end
    if (cmd.load) begin
      rd_addr <= '0;
      hit     <= 1'b0;
    end else begin
      if (rd_en) rd_addr <= rd_addr + CW'(1);
      if (rd_pending && (slot_s < req_e) && (req_s < slot_e)) hit <= 1'b1;
    end
  end

  // Fill count, read pipeline flag and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_pending <= rd_en;
      if (store) count <= count + CW'(1);
      if (cmd.decide) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      status <= status_next;
      booked <= (status_next == ibt_pkg::ST_BOOKED);
    end
  end

endmodule
`default_nettype wire

FILE: src/interval_booking_table_top.sv
// Top level of the interval booking table: controller plus datapath.
// The controller takes a request, scans the stored intervals and then decides; for a
// valid request the scan reads one stored interval per cycle from the RAM, whose read
// data is registered. The decision waits while an earlier result still waits.
// The next request is taken the cycle after the result is loaded, so the table does
// not take a new request before it is through with the last one.
`timescale 1ns / 1ps
`default_nettype none
module interval_booking_table_top #(
  parameter int CAPACITY = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [ibt_pkg::TIME_W-1:0] req_start,
  input  wire logic [ibt_pkg::TIME_W-1:0] req_end,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      status,
  output logic                            booked
);

  ibt_pkg::ibt_cmd_t cmd;
  ibt_pkg::ibt_sts_t sts;

  ibt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  ibt_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_start(req_start),
    .req_end  (req_end),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .booked   (booked)
  );

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the interval booking table top level.
`timescale 1ns / 1ps
module testbench;

  localparam int TW = ibt_pkg::TIME_W;
  localparam int CAPACITY = 64;
  localparam longint MAX_T = 64'h7FFF_FFFF;
  localparam int RAND_ITEMS = 1400;
  localparam int END_DRAIN = 100;

  typedef struct {
    logic [TW-1:0] t_start;
    logic [TW-1:0] t_stop;
  } booking_req_t;

  typedef struct {
    logic [1:0] status;
    logic       booked;
  } booking_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [TW-1:0] req_start = '0;
  logic [TW-1:0] req_end = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic booked;

  interval_booking_table_top #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_start(req_start),
    .req_end(req_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .booked(booked)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the booking table.
  logic [TW-1:0] tbl_start [CAPACITY];
  logic [TW-1:0] tbl_end [CAPACITY];
  int tbl_count = 0;

  booking_req_t request_q[$];
  booking_result_t answer_q[$];
  int sent_count = 0;
  int accepted_count = 0;
  int result_count = 0;
  int error_count = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  bit calm = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  // Decides one booking request against the shadow table and stores it if it fits.
  function automatic logic [1:0] book_interval(logic [TW-1:0] s, logic [TW-1:0] e);
    logic hit;
    hit = 1'b0;
    if (e <= s) return ibt_pkg::ST_INVALID;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_start[i] < e && s < tbl_end[i]) hit = 1'b1;
    end
    if (hit) return ibt_pkg::ST_OVERLAP;
    if (tbl_count >= CAPACITY) return ibt_pkg::ST_FULL;
    tbl_start[tbl_count] = s;
    tbl_end[tbl_count] = e;
    tbl_count++;
    return ibt_pkg::ST_BOOKED;
  endfunction

  function automatic longint clamp_time(longint v);
    if (v < 0) return 0;
    if (v > MAX_T) return MAX_T;
    return v;
  endfunction

  function automatic longint rand_between(longint lo, longint hi);
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 100);
  endfunction

  // Builds a request aimed at the current table contents.
  function automatic booking_req_t make_request();
    booking_req_t r;
    int pick;
    int idx;
    int fit_lim;
    longint s;
    longint e;
    longint a;
    longint b;
    longint t;
    fit_lim = (tbl_count < CAPACITY) ? 15 : 30;
    pick = $urandom_range(0, 99);
    idx = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
    s = (tbl_count > 0) ? longint'(tbl_start[idx]) : 0;
    e = (tbl_count > 0) ? longint'(tbl_end[idx]) : 1;
    if (tbl_count == 0 || (pick < fit_lim && pick % 3 == 0)) begin
      // Fresh interval somewhere in the time range.
      a = longint'($urandom) & MAX_T;
      b = a + (($urandom_range(0, 7) == 0) ? $urandom_range(1, 1 << 20)
                                            : $urandom_range(1, 4096));
    end else if (pick < fit_lim && pick % 3 == 1) begin
      // Starts exactly where a stored interval ends.
      a = e;
      b = e + $urandom_range(1, 4096);
    end else if (pick < fit_lim) begin
      // Ends exactly where a stored interval starts.
      b = s;
      a = s - $urandom_range(1, 4096);
    end else if (pick < fit_lim + 50) begin
      // Overlaps a stored interval: partial, containing, contained or identical.
      if ($urandom_range(0, 4) == 0) begin
        a = s;
        b = e;
      end else begin
        a = rand_between(clamp_time(s - $urandom_range(0, 64)), e - 1);
        b = rand_between((a > s) ? a + 1 : s + 1, clamp_time(e + $urandom_range(0, 64)));
      end
    end else if (pick < fit_lim + 60) begin
      // Empty or reversed interval.
      a = longint'($urandom) & MAX_T;
      b = $urandom_range(0, 1) ? a : rand_between(0, a);
    end else begin
      // Arbitrary bits; kept reversed or empty until the table is full so no huge block books.
      a = longint'($urandom) & MAX_T;
      b = longint'($urandom) & MAX_T;
      if (tbl_count < CAPACITY && b > a) begin
        t = a;
        a = b;
        b = t;
      end
    end
    r.t_start = TW'(clamp_time(a));
    r.t_stop = TW'(clamp_time(b));
    return r;
  endfunction

  task automatic queue_request(longint s, longint e);
    booking_req_t r;
    r.t_start = TW'(s);
    r.t_stop = TW'(e);
    request_q = {request_q, r};
    sent_count++;
  endtask

  task automatic report_mismatch(string what);
    if (error_count < 50) $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Request driver: holds each request until accepted, predicts it on acceptance.
  always @(posedge clk) begin
    booking_req_t item;
    booking_result_t want;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        want.status = book_interval(req_start, req_end);
        want.booked = (want.status == ibt_pkg::ST_BOOKED);
        answer_q = {answer_q, want};
        status_seen[want.status]++;
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          item = request_q.pop_front();
          req_start <= item.t_start;
          req_end <= item.t_stop;
          in_valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure, compares each result with the oldest answer.
  always @(posedge clk) begin
    booking_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (answer_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: status %0d booked %0d",
                                    status, booked));
        end else begin
          want = answer_q.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("result %0d: status %0d, wanted %0d",
                                      result_count, status, want.status));
          if (booked !== want.booked)
            report_mismatch($sformatf("result %0d: booked %0d, wanted %0d",
                                      result_count, booked, want.booked));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      out_ready <= (stall_left == 0);
    end
  end

  // Reset, directed requests, random requests, then drain and verdict.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Empty and reversed intervals at the extremes.
    queue_request(MAX_T, MAX_T);
    queue_request(0, 0);
    queue_request(MAX_T, 0);
    queue_request(100, 99);
    queue_request(64'h5555_5555, 64'h2AAA_AAAA);
    // Shortest intervals at both ends of the time range.
    queue_request(0, 1);
    queue_request(MAX_T - 1, MAX_T);
    // Whole range overlaps what is stored.
    queue_request(0, MAX_T);
    // Touching intervals book; overlapping ones are refused.
    queue_request(1, 10);
    queue_request(10, 20);
    queue_request(5, 15);
    queue_request(10, 20);
    queue_request(12, 13);
    queue_request(9, 21);
    queue_request(19, 21);
    queue_request(MAX_T - 2, MAX_T - 1);
    queue_request(MAX_T - 3, MAX_T);
    queue_request(64'h2AAA_AAAA, 64'h2AAA_AAAB);
    queue_request(64'h5555_5554, 64'h5555_5555);
    queue_request(20, 21);
    queue_request(0, 2);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      while (request_q.size() >= 2) @(negedge clk);
      if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      request_q = {request_q, make_request()};
      sent_count++;
    end

    while (accepted_count != sent_count) @(negedge clk);
    while (answer_q.size() > 0) @(negedge clk);
    repeat (END_DRAIN) @(negedge clk);

    $display("testbench: %0d requests, %0d results; booked %0d, overlap %0d, full %0d,",
             accepted_count, result_count, status_seen[ibt_pkg::ST_BOOKED],
             status_seen[ibt_pkg::ST_OVERLAP], status_seen[ibt_pkg::ST_FULL]);
    $display("testbench: invalid %0d, table holds %0d of %0d, %0d mismatches",
             status_seen[ibt_pkg::ST_INVALID], tbl_count, CAPACITY, error_count);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

FILE: sim.f
src/ibt_pkg.sv
src/ibt_ram.sv
src/ibt_ctrl.sv
src/ibt_dp.sv
src/interval_booking_table_top.sv
verif/testbench.sv
